### hw/rtl/fcr_pkg.sv
// package with the round permutations, request codes and byte helpers
`timescale 1ns / 1ps

package fcr_pkg;

	typedef logic [15:0][7:0] block_t;
	typedef logic [7:0][7:0]  tweakey_t;

	typedef enum logic [1:0] {
		PERM_ENC  = 2'd0,
		PERM_DEC  = 2'd1,
		PERM_NONE = 2'd2,
		PERM_SKIP = 2'd3
	} perm_mode_t;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_ROUND = 1'b1;

	localparam int unsigned NUM_LANES = 8;
	localparam int unsigned SBOX_DEPTH = 256;

	localparam logic [3:0] PERM_ENC_MAP [16] = '{
		4'd13, 4'd9, 4'd14, 4'd8, 4'd10, 4'd11, 4'd12, 4'd15,
		4'd4, 4'd5, 4'd3, 4'd1, 4'd2, 4'd6, 4'd0, 4'd7
	};
	localparam logic [3:0] PERM_DEC_MAP [16] = '{
		4'd14, 4'd11, 4'd12, 4'd10, 4'd8, 4'd9, 4'd13, 4'd15,
		4'd3, 4'd1, 4'd4, 4'd5, 4'd6, 4'd0, 4'd2, 4'd7
	};

	// byte i moves to position map[i]
	function automatic block_t permute(input block_t st, input perm_mode_t mode);
		block_t nx;
		nx = st;
		for (int i = 0; i < 16; i++) begin
			if (mode == PERM_ENC) begin
				nx[PERM_ENC_MAP[i]] = st[i];
			end else if (mode == PERM_DEC) begin
				nx[PERM_DEC_MAP[i]] = st[i];
			end
		end
		return nx;
	endfunction

	// linear layer: byte 15 takes bytes 1..7, bytes 9..14 take byte 7
	function automatic block_t diffusion_layer(input block_t st);
		block_t nx;
		nx = st;
		nx[15] = st[15] ^ st[1] ^ st[2] ^ st[3] ^ st[4] ^ st[5] ^ st[6] ^ st[7];
		for (int i = 9; i < 15; i++) begin
			nx[i] = st[i] ^ st[7];
		end
		return nx;
	endfunction

endpackage

### hw/rtl/feistel_cipher_round_loadable_sbox.sv
// top level: one feistel round with a loadable s-box, three register stages
`timescale 1ns / 1ps
//
// Input channel (in_valid / in_ready) takes two kinds of items. A load item
// (req_type 0) writes sbox_data into s-box entry sbox_addr and gives no
// result. A round item (req_type 1) carries state_lo/state_hi, round_key and
// perm_mode and gives one result on the output channel (out_valid /
// out_ready) as result_lo/result_hi.
// Throughput: one item per cycle while the output is not stalled. A round
// item passes three register stages (s-box read, nonlinear layer, linear
// layer with permutation into the output register); out_valid rises when
// the item reaches the output register.
// The s-box is held in eight copies, one per nonlinear lane, each with one
// write and one read port; a load writes all copies in its transfer cycle
// and a round accepted in the very next cycle already sees it.
// Reset clears the pipeline valid bits only; s-box entries are undefined
// until loaded. When the receiver stalls the whole pipeline holds and
// in_ready drops, so no item is lost or repeated.
//
module feistel_cipher_round_loadable_sbox
	import fcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  sbox_addr,
	input  logic [7:0]  sbox_data,
	input  logic [63:0] state_lo,
	input  logic [63:0] state_hi,
	input  logic [63:0] round_key,
	input  logic [1:0]  perm_mode,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_lo,
	output logic [63:0] result_hi
);

	logic       advance;
	logic       load_xfer;
	logic       round_xfer;
	block_t     st_in;
	tweakey_t   tk_in;
	logic [7:0] sbox_idx [NUM_LANES];

	logic       valid_s1, valid_s2, valid_s3;
	block_t     st_s1, st_s2, st_s3;
	perm_mode_t mode_s1, mode_s2;
	logic [7:0] sbox_rd_s1 [NUM_LANES];
	block_t     nl_st;

	assign advance    = !valid_s3 || out_ready;
	assign in_ready   = advance;
	assign load_xfer  = in_valid && advance && (req_type == REQ_LOAD);
	assign round_xfer = in_valid && advance && (req_type == REQ_ROUND);

	assign st_in = {state_hi, state_lo};
	assign tk_in = round_key;

	// s-box copies, one per lane
	for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
		logic [7:0] sbox_mem [SBOX_DEPTH];

		assign sbox_idx[k] = st_in[k] ^ tk_in[k];

		always_ff @(posedge clk) begin
			if (load_xfer) begin
				sbox_mem[sbox_addr] <= sbox_data;
			end
			if (advance) begin
				sbox_rd_s1[k] <= sbox_mem[sbox_idx[k]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= round_xfer;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		nl_st = st_s1;
		if (mode_s1 != PERM_SKIP) begin
			for (int k = 0; k < NUM_LANES; k++) begin
				nl_st[15 - k] = st_s1[15 - k] ^ sbox_rd_s1[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			st_s1   <= st_in;
			mode_s1 <= perm_mode_t'(perm_mode);
			st_s2   <= nl_st;
			mode_s2 <= mode_s1;
			if (mode_s2 == PERM_SKIP) begin
				st_s3 <= st_s2;
			end else begin
				st_s3 <= permute(diffusion_layer(st_s2), mode_s2);
			end
		end
	end

	assign out_valid = valid_s3;
	assign result_lo = st_s3[7:0];
	assign result_hi = st_s3[15:8];

endmodule

### hw/rtl/fcr_checker.sv
// port checker for the feistel round block, bound to the top level
`timescale 1ns / 1ps

module fcr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        req_type,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] result_lo,
	input logic [63:0] result_hi
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_lo) && $stable(result_hi))
		else $error("stalled result changed");

	// input side only blocks behind a stalled result
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output stall");

	// a round reaches the output if in_ready stays high while it moves through
	a_round_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && req_type) ##1 in_ready ##1 in_ready |=> out_valid)
		else $error("round result missing after pipeline latency");

	// a load on an empty pipeline never makes a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !req_type && !out_valid) ##1 (!in_valid && !out_valid)
			##1 (!in_valid && !out_valid) |=> !out_valid || $past(out_valid, 3))
		else $error("load transfer produced a result");

endmodule

bind feistel_cipher_round_loadable_sbox fcr_checker u_fcr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.req_type  (req_type),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.result_lo (result_lo),
	.result_hi (result_hi)
);
